// ===== sv/wsts_pkg.sv =====
// ----------------------------------------------------------------------------
// wsts_pkg
// Shared types and codes for the work-stealing task scheduler: request kinds,
// result status codes, controller states and the controller/datapath
// command and status groups.
// ----------------------------------------------------------------------------
package wsts_pkg;

	// Number of worker deques. The worker and queue fields are three bits wide,
	// so this is fixed for the block.
	localparam int NUM_WORKERS = 8;

	// Request kinds carried on func.
	localparam logic [1:0] FUNC_SUBMIT = 2'd0;
	localparam logic [1:0] FUNC_FETCH  = 2'd1;
	localparam logic [1:0] FUNC_STOP   = 2'd2;
	localparam logic [1:0] FUNC_NONE   = 2'd3;

	// Result status codes.
	localparam logic [2:0] STAT_SUBMITTED   = 3'd0;
	localparam logic [2:0] STAT_REJ_STOPPED = 3'd1;
	localparam logic [2:0] STAT_REJ_FULL    = 3'd2;
	localparam logic [2:0] STAT_GRANTED     = 3'd3;
	localparam logic [2:0] STAT_WAIT        = 3'd4;
	localparam logic [2:0] STAT_EXIT        = 3'd5;
	localparam logic [2:0] STAT_STOP_ACK    = 3'd6;

	// Reset value of the active worker register.
	localparam logic [3:0] ACTIVE_RESET = 4'd8;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_RESP
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;     // capture the request word
		logic rr_step;  // pull the round-robin pointer back into the active range
		logic exec;     // carry out the request and register the result
		logic cfg_we;   // write the active worker register
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic rr_ge_act;  // a round-robin submit finds the pointer outside the active range
		logic no_result;  // captured request is of an unknown kind
	} stat_t;

endpackage

// ===== sv/wsts_ctrl.sv =====
// ----------------------------------------------------------------------------
// wsts_ctrl
// Controller of the scheduler: sequences accept, execute and result cycles
// and issues the datapath commands.
// ----------------------------------------------------------------------------
module wsts_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic            cfg_valid,
	input  wsts_pkg::stat_t stat,
	output wsts_pkg::cmd_t  cmd,
	output logic            busy,
	output logic            done,
	output logic            cfg_ready
);

	wsts_pkg::state_t state_q;
	wsts_pkg::state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= wsts_pkg::S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			wsts_pkg::S_IDLE, wsts_pkg::S_RESP: begin
				state_nxt = start ? wsts_pkg::S_EXEC : wsts_pkg::S_IDLE;
			end
			wsts_pkg::S_EXEC: begin
				if (stat.rr_ge_act) begin
					state_nxt = wsts_pkg::S_EXEC;
				end else if (stat.no_result) begin
					state_nxt = wsts_pkg::S_IDLE;
				end else begin
					state_nxt = wsts_pkg::S_RESP;
				end
			end
			default: begin
				state_nxt = wsts_pkg::S_IDLE;
			end
		endcase
	end

	always_comb begin
		busy        = 1'b0;
		done        = 1'b0;
		cmd.rr_step = 1'b0;
		cmd.exec    = 1'b0;
		case (state_q)
			wsts_pkg::S_IDLE: begin
				busy = 1'b0;
			end
			wsts_pkg::S_EXEC: begin
				busy        = 1'b1;
				cmd.rr_step = stat.rr_ge_act;
				cmd.exec    = !stat.rr_ge_act;
			end
			wsts_pkg::S_RESP: begin
				done = 1'b1;
			end
			default: begin
				busy = 1'b0;
			end
		endcase
		cmd.load   = start && !busy;
		cfg_ready  = !busy;
		cmd.cfg_we = cfg_valid && !busy;
	end

endmodule

// ===== sv/wsts_dpath.sv =====
// ----------------------------------------------------------------------------
// wsts_dpath
// Datapath of the scheduler: per-queue head and count registers, the task
// store, the round-robin pointer, the steal search and the result registers.
// ----------------------------------------------------------------------------
module wsts_dpath #(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  wsts_pkg::cmd_t  cmd,
	output wsts_pkg::stat_t stat,
	input  logic [1:0]      func,
	input  logic            from_worker,
	input  logic [2:0]      worker,
	input  logic [15:0]     task_id,
	input  logic [3:0]      cfg_data,
	output logic [2:0]      status,
	output logic [15:0]     granted_task,
	output logic [2:0]      source_queue,
	output logic            stolen
);

	localparam int NUM_WORKERS = wsts_pkg::NUM_WORKERS;
	localparam int QW   = $clog2(NUM_WORKERS);
	localparam int SW   = $clog2(QUEUE_DEPTH);
	localparam int CW   = $clog2(QUEUE_DEPTH + 1);
	localparam int AW   = $clog2(NUM_WORKERS + 1);
	localparam int MEMD = NUM_WORKERS * (2 ** SW);

	logic [3:0]    cfg_q;
	logic [AW-1:0] act;

	logic [1:0]  func_q;
	logic        fw_q;
	logic [2:0]  worker_q;
	logic [15:0] task_q;

	logic [QW-1:0] rr_q;
	logic [SW-1:0] head_q  [NUM_WORKERS];
	logic [CW-1:0] count_q [NUM_WORKERS];
	logic          stopped_q;

	logic [15:0] mem [MEMD];
	logic [15:0] rd_q;

	logic [2:0]  status_q;
	logic [2:0]  queue_q;
	logic        stolen_q;
	logic        grant_q;

	logic                   wk_act;
	logic                   use_rr;
	logic [QW-1:0]          own_q;
	logic [QW-1:0]          sub_q;
	logic [QW-1:0]          rr_wrap;
	logic [NUM_WORKERS-1:0] nonempty;
	logic                   own_ne;
	logic                   hit_hi;
	logic                   hit_lo;
	logic [QW-1:0]          v_hi;
	logic [QW-1:0]          v_lo;
	logic                   steal_hit;
	logic [QW-1:0]          steal_v;
	logic [QW-1:0]          sel;
	logic [SW-1:0]          h;
	logic [CW-1:0]          c;
	int                     sum_tail;
	int                     sum_top;
	int                     sum_next;
	logic [SW-1:0]          slot_tail;
	logic [SW-1:0]          slot_top;
	logic [SW-1:0]          slot_next;
	logic                   full;

	logic          do_write;
	logic          do_read;
	logic [SW-1:0] slot_sel;
	logic          cnt_inc;
	logic          cnt_dec;
	logic          head_adv;
	logic          rr_adv;
	logic          set_stop;
	logic [2:0]    res_status;
	logic          res_qsel;
	logic          res_stolen;
	logic [QW+SW-1:0] addr;

	// Zero active workers acts as one; more than the hardware has acts as all.
	always_comb begin
		if (cfg_q == 4'd0) begin
			act = AW'(1);
		end else if (32'(cfg_q) > NUM_WORKERS) begin
			act = AW'(NUM_WORKERS);
		end else begin
			act = AW'(cfg_q);
		end
	end

	assign wk_act  = 32'(worker_q) < 32'(act);
	assign own_q   = QW'(worker_q);
	assign use_rr  = !(fw_q && wk_act);
	assign sub_q   = use_rr ? rr_q : own_q;
	assign rr_wrap = (32'(rr_q) + 1 == 32'(act)) ? '0 : QW'(rr_q + 1'b1);

	always_comb begin
		for (int j = 0; j < NUM_WORKERS; j++) begin
			nonempty[j] = count_q[j] != '0;
		end
	end

	assign own_ne = wk_act && nonempty[own_q];

	// Ring search: the first non-empty active queue above the worker wins,
	// otherwise the first one below it.
	always_comb begin
		hit_hi = 1'b0;
		hit_lo = 1'b0;
		v_hi   = '0;
		v_lo   = '0;
		for (int j = NUM_WORKERS - 1; j >= 0; j--) begin
			if (nonempty[j] && j < int'(act)) begin
				if (j > int'(worker_q)) begin
					hit_hi = 1'b1;
					v_hi   = QW'(j);
				end else if (j < int'(worker_q)) begin
					hit_lo = 1'b1;
					v_lo   = QW'(j);
				end
			end
		end
	end

	assign steal_hit = wk_act && (hit_hi || hit_lo);
	assign steal_v   = hit_hi ? v_hi : v_lo;

	assign sel = (func_q == wsts_pkg::FUNC_SUBMIT) ? sub_q : (own_ne ? own_q : steal_v);
	assign h   = head_q[sel];
	assign c   = count_q[sel];

	// Head plus count stays below twice the depth, so one subtract wraps it.
	always_comb begin
		sum_tail = int'(h) + int'(c);
		sum_top  = sum_tail - 1;
		sum_next = int'(h) + 1;
		if (sum_tail >= QUEUE_DEPTH) begin
			sum_tail = sum_tail - QUEUE_DEPTH;
		end
		if (sum_top >= QUEUE_DEPTH) begin
			sum_top = sum_top - QUEUE_DEPTH;
		end
		if (sum_next >= QUEUE_DEPTH) begin
			sum_next = sum_next - QUEUE_DEPTH;
		end
	end

	assign slot_tail = SW'(sum_tail);
	assign slot_top  = SW'(sum_top);
	assign slot_next = SW'(sum_next);
	assign full      = 32'(c) >= QUEUE_DEPTH;

	always_comb begin
		do_write   = 1'b0;
		do_read    = 1'b0;
		slot_sel   = h;
		cnt_inc    = 1'b0;
		cnt_dec    = 1'b0;
		head_adv   = 1'b0;
		rr_adv     = 1'b0;
		set_stop   = 1'b0;
		res_status = wsts_pkg::STAT_WAIT;
		res_qsel   = 1'b0;
		res_stolen = 1'b0;
		case (func_q)
			wsts_pkg::FUNC_STOP: begin
				set_stop   = 1'b1;
				res_status = wsts_pkg::STAT_STOP_ACK;
			end
			wsts_pkg::FUNC_SUBMIT: begin
				if (stopped_q) begin
					res_status = wsts_pkg::STAT_REJ_STOPPED;
				end else begin
					rr_adv   = use_rr;
					res_qsel = 1'b1;
					if (full) begin
						res_status = wsts_pkg::STAT_REJ_FULL;
					end else begin
						do_write   = 1'b1;
						slot_sel   = slot_tail;
						cnt_inc    = 1'b1;
						res_status = wsts_pkg::STAT_SUBMITTED;
					end
				end
			end
			wsts_pkg::FUNC_FETCH: begin
				if (own_ne) begin
					do_read    = 1'b1;
					slot_sel   = slot_top;
					cnt_dec    = 1'b1;
					res_status = wsts_pkg::STAT_GRANTED;
					res_qsel   = 1'b1;
				end else if (steal_hit) begin
					do_read    = 1'b1;
					slot_sel   = h;
					cnt_dec    = 1'b1;
					head_adv   = 1'b1;
					res_status = wsts_pkg::STAT_GRANTED;
					res_qsel   = 1'b1;
					res_stolen = 1'b1;
				end else begin
					res_status = stopped_q ? wsts_pkg::STAT_EXIT : wsts_pkg::STAT_WAIT;
				end
			end
			default: begin
				res_status = wsts_pkg::STAT_WAIT;
			end
		endcase
	end

	assign addr = {sel, slot_sel};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q     <= wsts_pkg::ACTIVE_RESET;
			rr_q      <= '0;
			stopped_q <= 1'b0;
			for (int j = 0; j < NUM_WORKERS; j++) begin
				head_q[j]  <= '0;
				count_q[j] <= '0;
			end
		end else begin
			if (cmd.cfg_we) begin
				cfg_q <= cfg_data;
			end
			if (cmd.rr_step) begin
				rr_q <= QW'(32'(rr_q) - 32'(act));
			end else if (cmd.exec && rr_adv) begin
				rr_q <= rr_wrap;
			end
			if (cmd.exec) begin
				if (set_stop) begin
					stopped_q <= 1'b1;
				end
				if (cnt_inc) begin
					count_q[sel] <= CW'(c + 1'b1);
				end else if (cnt_dec) begin
					count_q[sel] <= CW'(c - 1'b1);
				end
				if (head_adv) begin
					head_q[sel] <= slot_next;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q   <= func;
			fw_q     <= from_worker;
			worker_q <= worker;
			task_q   <= task_id;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec && do_write) begin
			mem[addr] <= task_q;
		end
		if (cmd.exec && do_read) begin
			rd_q <= mem[addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			status_q <= res_status;
			queue_q  <= res_qsel ? 3'(sel) : 3'd0;
			stolen_q <= res_stolen;
			grant_q  <= res_status == wsts_pkg::STAT_GRANTED;
		end
	end

	// The pointer is only folded when a round-robin submit is about to use it,
	// so a later change of the active count still sees the unfolded value.
	assign stat.rr_ge_act = (func_q == wsts_pkg::FUNC_SUBMIT) && !stopped_q && use_rr &&
		(32'(rr_q) >= 32'(act));
	assign stat.no_result = func_q == wsts_pkg::FUNC_NONE;

	assign status       = status_q;
	assign granted_task = grant_q ? rd_q : 16'd0;
	assign source_queue = queue_q;
	assign stolen       = stolen_q;

endmodule

// ===== sv/work_stealing_task_scheduler.sv =====
// ----------------------------------------------------------------------------
// work_stealing_task_scheduler
// Hardware task scheduler with one bounded deque per active worker. Submits
// go to the worker's own deque or round-robin; fetches pop LIFO from the own
// deque or steal FIFO from the next non-empty deque in ring order.
// ----------------------------------------------------------------------------
//
// Channel   Signals                                     Transfer
// --------  ------------------------------------------  -------------------------
// request   start, busy, func, from_worker, worker,     start high, busy low
//           task_id
// result    done, status, granted_task, source_queue,   done high, one cycle
//           stolen
// config    cfg_valid, cfg_ready, cfg_data              cfg_valid and cfg_ready
//
// A word has an execute state with busy high that updates the deques and registers
// the result, then a state with done high (none for an unknown kind) in which the
// next word can be accepted. A round-robin submit meeting a pointer beyond a lowered
// active count first stays busy, subtracting that count until the pointer is in
// range. Reset clears heads, counts, the pointer and the stop flag; the task store is
// not cleared. The receiver cannot stall: each result shows for exactly one cycle.
//
module work_stealing_task_scheduler #(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  func,
	input  logic        from_worker,
	input  logic [2:0]  worker,
	input  logic [15:0] task_id,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [3:0]  cfg_data,
	output logic        done,
	output logic [2:0]  status,
	output logic [15:0] granted_task,
	output logic [2:0]  source_queue,
	output logic        stolen
);

	// Commands and status between the controller and the datapath.
	wsts_pkg::cmd_t  cmd;
	wsts_pkg::stat_t stat;

	// The controller decides when a word is taken in, when it executes and
	// when its result is shown.
	wsts_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.cfg_valid (cfg_valid),
		.stat      (stat),
		.cmd       (cmd),
		.busy      (busy),
		.done      (done),
		.cfg_ready (cfg_ready)
	);

	// The datapath holds the deques, the task store and the result registers.
	wsts_dpath #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.func         (func),
		.from_worker  (from_worker),
		.worker       (worker),
		.task_id      (task_id),
		.cfg_data     (cfg_data),
		.status       (status),
		.granted_task (granted_task),
		.source_queue (source_queue),
		.stolen       (stolen)
	);

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the work-stealing task scheduler. A queue of request
// words, register writes and pauses drives the block. A scoreboard keeps its
// own copy of the deques and predicts every reply, which is then checked field
// by field against what the block returns.
// ----------------------------------------------------------------------------
module tb;

	localparam int NW            = wsts_pkg::NUM_WORKERS;  // worker deques
	localparam int QDEPTH        = 16;  // slots per deque
	localparam int SETTLE_CYCLES = 6;   // quiet cycles before a register write
	localparam int TAIL_CYCLES   = 20;  // watch for stray replies at the end

	// Kinds of entries on the stimulus queue. Only words and register writes
	// reach the block; pauses and phase markers steer the driver.
	typedef enum logic [1:0] {
		ENT_WORD,
		ENT_CFG,
		ENT_DRAIN,
		ENT_PHASE
	} entry_kind_t;

	typedef struct packed {
		entry_kind_t kind;
		logic [1:0]  func;
		logic        from_worker;
		logic [2:0]  worker;
		logic [15:0] task_id;
		logic [7:0]  arg;          // register value, or sender idle percentage
	} entry_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [15:0] task_tag;
		logic [2:0]  queue;
		logic        stolen;
	} sched_reply_t;

	logic        clk         = 1'b0;
	logic        arst_n      = 1'b0;
	logic        start       = 1'b0;
	logic        busy;
	logic [1:0]  func        = wsts_pkg::FUNC_SUBMIT;
	logic        from_worker = 1'b0;
	logic [2:0]  worker      = 3'd0;
	logic [15:0] task_id     = 16'd0;
	logic        cfg_valid   = 1'b0;
	logic        cfg_ready;
	logic [3:0]  cfg_data    = 4'd0;
	logic        done;
	logic [2:0]  status;
	logic [15:0] granted_task;
	logic [2:0]  source_queue;
	logic        stolen;

	work_stealing_task_scheduler #(
		.QUEUE_DEPTH(QDEPTH)
	) i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.func        (func),
		.from_worker (from_worker),
		.worker      (worker),
		.task_id     (task_id),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data),
		.done        (done),
		.status      (status),
		.granted_task(granted_task),
		.source_queue(source_queue),
		.stolen      (stolen)
	);

	// Stimulus still to be sent, and the replies that are owed by the block.
	entry_t       request_words[$];
	sched_reply_t sched_replies[$];
	int           bad_replies = 0;

	// Scoreboard copy of the scheduler state.
	logic [15:0] deque_mem[NW][QDEPTH];
	logic [3:0]  deque_head[NW];
	logic [4:0]  deque_count[NW];
	logic [2:0]  rr_ptr;
	logic        pool_stopped;
	logic [3:0]  active_cfg;

	// Driver scratch.
	int           sender_idle_pct = 0;
	int           quiet_cycles    = 0;
	bit           word_fire;
	bit           cfg_fire;
	bit           drive_word;
	bit           drive_cfg;
	bit           settled;
	sched_reply_t reply;

	// Apply one accepted word to the scoreboard state and work out the reply.
	// Returns 0 for a request kind that the block ignores.
	function automatic bit schedule_word(input entry_t w, output sched_reply_t r);
		int act;
		int q;
		int slot;
		int v;
		r = '0;
		// A zero setting behaves as one deque, anything above the build as all.
		act = (active_cfg == 4'd0) ? 1 : ((active_cfg > NW) ? NW : int'(active_cfg));
		case (w.func)
			wsts_pkg::FUNC_STOP: begin
				pool_stopped = 1'b1;
				r.status = wsts_pkg::STAT_STOP_ACK;
				return 1'b1;
			end
			wsts_pkg::FUNC_SUBMIT: begin
				if (pool_stopped) begin
					r.status = wsts_pkg::STAT_REJ_STOPPED;
					return 1'b1;
				end
				// A worker outside the active set submits as an outsider would.
				if (w.from_worker && w.worker < act) begin
					q = int'(w.worker);
				end else begin
					q = int'(rr_ptr) % act;
					rr_ptr = 3'((q + 1) % act);
				end
				r.queue = 3'(q);
				if (deque_count[q] >= QDEPTH) begin
					r.status = wsts_pkg::STAT_REJ_FULL;
					return 1'b1;
				end
				slot = (int'(deque_head[q]) + int'(deque_count[q])) % QDEPTH;
				deque_mem[q][slot] = w.task_id;
				deque_count[q] = 5'(deque_count[q] + 1);
				r.status = wsts_pkg::STAT_SUBMITTED;
				return 1'b1;
			end
			wsts_pkg::FUNC_FETCH: begin
				if (w.worker < act) begin
					// Own deque first, newest task.
					if (deque_count[w.worker] > 0) begin
						deque_count[w.worker] = 5'(deque_count[w.worker] - 1);
						slot = (int'(deque_head[w.worker]) + int'(deque_count[w.worker]))
							% QDEPTH;
						r.status   = wsts_pkg::STAT_GRANTED;
						r.task_tag = deque_mem[w.worker][slot];
						r.queue    = w.worker;
						return 1'b1;
					end
					// Then the oldest task of the next busy deque around the ring.
					for (int i = 1; i < act; i++) begin
						v = (int'(w.worker) + i) % act;
						if (deque_count[v] > 0) begin
							r.status   = wsts_pkg::STAT_GRANTED;
							r.task_tag = deque_mem[v][deque_head[v]];
							r.queue    = 3'(v);
							r.stolen   = 1'b1;
							deque_head[v]  = 4'((int'(deque_head[v]) + 1) % QDEPTH);
							deque_count[v] = 5'(deque_count[v] - 1);
							return 1'b1;
						end
					end
				end
				r.status = pool_stopped ? wsts_pkg::STAT_EXIT : wsts_pkg::STAT_WAIT;
				return 1'b1;
			end
			default: return 1'b0;
		endcase
	endfunction

	task automatic add_word(input logic [1:0] f, input logic fw, input logic [2:0] w,
			input logic [15:0] tag);
		entry_t e;
		e = '0;
		e.kind        = ENT_WORD;
		e.func        = f;
		e.from_worker = fw;
		e.worker      = w;
		e.task_id     = tag;
		request_words.push_back(e);
	endtask

	task automatic add_control(input entry_kind_t k, input logic [7:0] value);
		entry_t e;
		e = '0;
		e.kind = k;
		e.arg  = value;
		request_words.push_back(e);
	endtask

	// Driver. At each edge it first retires whatever the block took, then, if
	// nothing is being held on the ports, picks the next thing to present.
	// start and cfg_valid each get exactly one assignment per edge at most.
	always @(posedge clk) begin
		if (arst_n) begin
			word_fire = start && !busy;
			cfg_fire  = cfg_valid && cfg_ready;
			if (word_fire) begin
				if (schedule_word(request_words[0], reply))
					sched_replies.push_back(reply);
				request_words.delete(0);
				quiet_cycles = 0;
			end else if (!busy && quiet_cycles < 255) begin
				quiet_cycles++;
			end
			if (cfg_fire) begin
				active_cfg = cfg_data;
				request_words.delete(0);
			end
			if ((!start || word_fire) && (!cfg_valid || cfg_fire)) begin
				drive_word = 1'b0;
				drive_cfg  = 1'b0;
				while (request_words.size() != 0 && request_words[0].kind == ENT_PHASE) begin
					sender_idle_pct = int'(request_words[0].arg);
					request_words.delete(0);
				end
				// The block counts as idle only once every owed reply is in and it
				// has had time to finish a word that returns nothing.
				settled = sched_replies.size() == 0 && quiet_cycles >= SETTLE_CYCLES && !busy;
				if (request_words.size() != 0) begin
					case (request_words[0].kind)
						ENT_DRAIN: begin
							if (settled)
								request_words.delete(0);
						end
						ENT_CFG: begin
							drive_cfg = settled;
						end
						default: begin
							drive_word = $urandom_range(99) >= sender_idle_pct;
						end
					endcase
				end
				start     <= drive_word;
				cfg_valid <= drive_cfg;
				if (drive_word) begin
					func        <= request_words[0].func;
					from_worker <= request_words[0].from_worker;
					worker      <= request_words[0].worker;
					task_id     <= request_words[0].task_id;
				end
				if (drive_cfg)
					cfg_data <= request_words[0].arg[3:0];
			end
		end
	end

	// Monitor. Each reply is live for one cycle only, so it is taken at the
	// edge that closes that cycle and checked against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (sched_replies.size() == 0) begin
				if (bad_replies < 10)
					$display("[%0t] reply with nothing owed: status %0d task %h queue %0d stolen %0d",
						$realtime, status, granted_task, source_queue, stolen);
				bad_replies++;
			end else begin
				reply = sched_replies[0];
				sched_replies.delete(0);
				if (status !== reply.status || granted_task !== reply.task_tag ||
						source_queue !== reply.queue || stolen !== reply.stolen) begin
					if (bad_replies < 10) begin
						$display("[%0t] reply mismatch: expected status %0d task %h queue %0d stolen %0d",
							$realtime, reply.status, reply.task_tag, reply.queue, reply.stolen);
						$display("    got status %0d task %h queue %0d stolen %0d",
							status, granted_task, source_queue, stolen);
					end
					bad_replies++;
				end
			end
		end
	end

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// A correct run takes a few tens of microseconds; this is far beyond it.
	initial begin
		#(2_000_000);
		$display("FAILURE");
		$finish;
	end

	initial begin
		int          cfg_plan[9];
		int          idle_plan[4];
		int          n;
		int          sel;
		int          len;
		logic [2:0]  w;

		for (int q = 0; q < NW; q++) begin
			deque_head[q]  = '0;
			deque_count[q] = '0;
		end
		rr_ptr       = '0;
		pool_stopped = 1'b0;
		active_cfg   = wsts_pkg::ACTIVE_RESET;

		// Directed opening at the reset setting of eight deques.
		add_word(wsts_pkg::FUNC_FETCH,  1'b1, 3'd0, 16'h0000);  // empty pool: wait
		add_word(wsts_pkg::FUNC_NONE,   1'b1, 3'd7, 16'hFFFF);  // unknown kind, no reply
		add_word(wsts_pkg::FUNC_SUBMIT, 1'b1, 3'd0, 16'h0000);
		add_word(wsts_pkg::FUNC_SUBMIT, 1'b1, 3'd7, 16'hFFFF);
		add_word(wsts_pkg::FUNC_SUBMIT, 1'b0, 3'd0, 16'h1234);  // round robin to deque 0
		add_word(wsts_pkg::FUNC_SUBMIT, 1'b0, 3'd3, 16'hA5A5);  // round robin to deque 1
		add_word(wsts_pkg::FUNC_FETCH,  1'b0, 3'd0, 16'h0000);  // newest of own deque
		add_word(wsts_pkg::FUNC_FETCH,  1'b0, 3'd0, 16'h0000);
		add_word(wsts_pkg::FUNC_FETCH,  1'b0, 3'd0, 16'h0000);  // own empty: steal from 1
		add_word(wsts_pkg::FUNC_FETCH,  1'b0, 3'd3, 16'h0000);  // ring search steals from 7
		add_word(wsts_pkg::FUNC_SUBMIT, 1'b1, 3'd5, 16'h5A5A);
		// One deque only: deque 5 keeps its task but drops out of sight, and a
		// stale round-robin pointer is folded back into range.
		add_control(ENT_CFG, 8'd0);
		add_word(wsts_pkg::FUNC_SUBMIT, 1'b1, 3'd3, 16'h0F0F);  // inactive worker submits
		add_word(wsts_pkg::FUNC_FETCH,  1'b0, 3'd2, 16'h0000);  // inactive worker fetches
		add_word(wsts_pkg::FUNC_FETCH,  1'b0, 3'd0, 16'h0000);
		add_word(wsts_pkg::FUNC_FETCH,  1'b0, 3'd0, 16'h0000);  // deque 5 is not scanned
		// Above the build size acts as all eight; deque 5 comes back.
		add_control(ENT_CFG, 8'd15);
		add_word(wsts_pkg::FUNC_FETCH,  1'b0, 3'd4, 16'h0000);
		add_word(wsts_pkg::FUNC_SUBMIT, 1'b0, 3'd6, 16'h8001);
		add_word(wsts_pkg::FUNC_FETCH,  1'b0, 3'd7, 16'h0000);

		// Random phases, each under its own deque count and one of four sender pacings.
		// The receiver cannot stall, so only the sender is paced.
		cfg_plan  = '{3, 8, 0, 15, 1, 5, 2, 12, 6};
		idle_plan = '{0, 56, 0, 30};
		for (int p = 0; p < 9; p++) begin
			add_control(ENT_CFG, 8'(cfg_plan[p]));
			add_control(ENT_PHASE, 8'(idle_plan[p % 4]));
			n = 0;
			while (n < 52) begin
				// Halfway through, hold off until the block has answered everything.
				if (n >= 26 && n < 28)
					add_control(ENT_DRAIN, 8'd0);
				sel = $urandom_range(99);
				if (sel < 5) begin
					// A burst from one worker, at times long enough to overfill its deque.
					w   = 3'($urandom_range(NW - 1));
					len = $urandom_range(12, 20);
					repeat (len)
						add_word(wsts_pkg::FUNC_SUBMIT, 1'b1, w, 16'($urandom));
					n += len;
				end else if (sel < 10) begin
					// A run of fetches that can empty deques and force steals.
					len = $urandom_range(6, 18);
					repeat (len)
						add_word(wsts_pkg::FUNC_FETCH, 1'($urandom),
							3'($urandom_range(NW - 1)), 16'($urandom));
					n += len;
				end else if (sel < 14) begin
					add_word(wsts_pkg::FUNC_NONE, 1'($urandom), 3'($urandom_range(NW - 1)),
						16'($urandom));
				end else if (sel < 58) begin
					add_word(wsts_pkg::FUNC_SUBMIT, 1'($urandom), 3'($urandom_range(NW - 1)),
						16'($urandom));
					n++;
				end else begin
					add_word(wsts_pkg::FUNC_FETCH, 1'($urandom), 3'($urandom_range(NW - 1)),
						16'($urandom));
					n++;
				end
			end
		end

		// Stop the pool last, since nothing can restart it: repeated stop,
		// rejected submits, then fetches that hand out remaining tasks or exit.
		add_control(ENT_PHASE, 8'd30);
		add_word(wsts_pkg::FUNC_STOP,   1'b0, 3'd0, 16'h0000);
		add_word(wsts_pkg::FUNC_STOP,   1'b1, 3'd7, 16'hFFFF);
		add_word(wsts_pkg::FUNC_SUBMIT, 1'b1, 3'd1, 16'h4321);
		add_word(wsts_pkg::FUNC_SUBMIT, 1'b0, 3'd2, 16'h1111);
		add_word(wsts_pkg::FUNC_FETCH,  1'b1, 3'd7, 16'h0000);  // outside the six active
		repeat (16)
			add_word(wsts_pkg::FUNC_FETCH, 1'($urandom), 3'($urandom_range(NW - 1)),
				16'($urandom));

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		while (request_words.size() != 0 || sched_replies.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		// Anything still owed at this point counts as a failure too.
		bad_replies += sched_replies.size();
		if (bad_replies == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
